>>> rtl/core/sdf_pkg.sv
// ----------------------------------------------------------------------------
// sdf_pkg
// Shared types and constants for the stream duplicate filter.
// ----------------------------------------------------------------------------
`default_nettype none

package sdf_pkg;

    localparam int VALUE_W           = 32;
    localparam int TABLE_DEPTH_DFLT  = 64;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic                      kept;
        logic                      overflow;
        logic                      last;
    } t_result;

endpackage

`default_nettype wire

>>> rtl/core/sdf_table.sv
// ----------------------------------------------------------------------------
// sdf_table
// Seen-value store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module sdf_table #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_wen,
    input  wire logic [AW-1:0]               i_waddr,
    input  wire logic [sdf_pkg::VALUE_W-1:0] i_wdata,
    input  wire logic                        i_ren,
    input  wire logic [AW-1:0]               i_raddr,
    output logic      [sdf_pkg::VALUE_W-1:0] o_rdata
);
    import sdf_pkg::*;

    logic [VALUE_W-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wen) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ren) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/sdf_ctrl.sv
// ----------------------------------------------------------------------------
// sdf_ctrl
// Scan sequencer: reads the store one entry a cycle, compares against the
// held value with the single comparator, then stores or drops.
// ----------------------------------------------------------------------------
`default_nettype none

module sdf_ctrl #(
    parameter int DEPTH = 64,
    parameter int AW    = 6,
    parameter int CW    = 7
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_in_fire,
    input  wire logic signed [sdf_pkg::VALUE_W-1:0] i_value,
    input  wire logic                               i_list_end,
    input  wire logic                               i_out_free,
    output logic                                    o_idle,
    output logic                                    o_res_vld,
    output sdf_pkg::t_result                        o_res,
    output logic                                    o_mem_ren,
    output logic [AW-1:0]                           o_mem_raddr,
    output logic                                    o_mem_wen,
    output logic [AW-1:0]                           o_mem_waddr,
    output logic [sdf_pkg::VALUE_W-1:0]             o_mem_wdata,
    input  wire logic [sdf_pkg::VALUE_W-1:0]        i_mem_rdata
);
    import sdf_pkg::*;

    t_state                    r_state, n_state;
    logic [CW-1:0]             r_idx,   n_idx;
    logic [CW-1:0]             r_count, n_count;
    logic                      r_pend,  n_pend;
    logic                      r_hit,   n_hit;
    logic signed [VALUE_W-1:0] r_value, n_value;
    logic                      r_last,  n_last;

    logic room;
    logic found;
    logic exhausted;

    assign room      = (r_count < CW'(DEPTH));
    assign found     = r_pend && (i_mem_rdata == r_value);
    assign exhausted = (r_idx == r_count);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_idx   <= '0;
            r_count <= '0;
            r_pend  <= 1'b0;
            r_hit   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_count <= n_count;
            r_pend  <= n_pend;
            r_hit   <= n_hit;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
        r_last  <= n_last;
    end

    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_count     = r_count;
        n_pend      = 1'b0;
        n_hit       = r_hit;
        n_value     = r_value;
        n_last      = r_last;
        o_mem_ren   = 1'b0;
        o_mem_raddr = r_idx[AW-1:0];
        o_mem_wen   = 1'b0;
        o_mem_waddr = r_count[AW-1:0];
        o_mem_wdata = r_value;
        o_res_vld   = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
                if (i_in_fire) begin
                    n_value = i_value;
                    n_last  = i_list_end;
                    n_idx   = '0;
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (found) begin
                    n_hit   = 1'b1;
                    n_state = ST_DONE;
                end else if (exhausted) begin
                    n_hit   = 1'b0;
                    n_state = ST_DONE;
                end else begin
                    // issue next read; its data is compared next cycle
                    o_mem_ren = 1'b1;
                    n_idx     = r_idx + CW'(1);
                    n_pend    = 1'b1;
                end
            end
            ST_DONE: begin
                o_res_vld = 1'b1;
                if (i_out_free) begin
                    o_mem_wen = !r_hit && room;
                    if (r_last) begin
                        n_count = '0;
                    end else if (!r_hit && room) begin
                        n_count = r_count + CW'(1);
                    end
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_idle         = (r_state == ST_IDLE);
    assign o_res.value    = r_value;
    assign o_res.kept     = !r_hit;
    assign o_res.overflow = !r_hit && !room;
    assign o_res.last     = r_last;

endmodule

`default_nettype wire

>>> rtl/core/stream_duplicate_filter_unit.sv
// ----------------------------------------------------------------------------
// stream_duplicate_filter_unit
// Keeps the first occurrence of each signed 32-bit value in a sequence.
// ----------------------------------------------------------------------------
// Input channel : i_valid / o_ready, payload i_value, i_list_end.
// Output channel: o_valid / i_ready, payload o_out_value, o_kept,
//                 o_overflow, o_out_last. One result per input transfer.
// Each value is checked against the entries stored so far in this sequence,
// read from the seen-value store one entry a cycle and compared by a single
// 32-bit comparator. A hit stops the scan early.
// A scan reads at most the stored count of entries, at most TABLE_DEPTH. The
// next input transfer is taken the cycle after the result is loaded into the
// output register, so the block takes no new value before it is done with
// the last one.
// A new value is stored while there is room; with the store full it is
// passed as kept with o_overflow set and not stored. The item with
// i_list_end set closes the sequence and empties the store.
// Reset empties the store at once (no clearing pass); entries are only read
// below the stored count. If the receiver stalls, the result waits in the
// output register and the sequencer holds its next result until it drains.
// ----------------------------------------------------------------------------
`default_nettype none

module stream_duplicate_filter_unit #(
    parameter int TABLE_DEPTH = sdf_pkg::TABLE_DEPTH_DFLT
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_valid,
    output logic                                    o_ready,
    input  wire logic signed [sdf_pkg::VALUE_W-1:0] i_value,
    input  wire logic                               i_list_end,
    output logic                                    o_valid,
    input  wire logic                               i_ready,
    output logic signed [sdf_pkg::VALUE_W-1:0]      o_out_value,
    output logic                                    o_kept,
    output logic                                    o_overflow,
    output logic                                    o_out_last
);
    import sdf_pkg::*;

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    logic               in_fire;
    logic               out_free;
    logic               ctrl_idle;
    logic               res_vld;
    logic               res_load;
    t_result            res;
    logic               mem_ren;
    logic [AW-1:0]      mem_raddr;
    logic               mem_wen;
    logic [AW-1:0]      mem_waddr;
    logic [VALUE_W-1:0] mem_wdata;
    logic [VALUE_W-1:0] mem_rdata;

    logic               r_out_vld;
    t_result            r_out;

    assign o_ready  = ctrl_idle;
    assign in_fire  = i_valid && ctrl_idle;
    // output register frees up when empty or being drained this cycle
    assign out_free = !r_out_vld || i_ready;
    assign res_load = res_vld && out_free;

    sdf_ctrl #(
        .DEPTH (TABLE_DEPTH),
        .AW    (AW),
        .CW    (CW)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_fire   (in_fire),
        .i_value     (i_value),
        .i_list_end  (i_list_end),
        .i_out_free  (out_free),
        .o_idle      (ctrl_idle),
        .o_res_vld   (res_vld),
        .o_res       (res),
        .o_mem_ren   (mem_ren),
        .o_mem_raddr (mem_raddr),
        .o_mem_wen   (mem_wen),
        .o_mem_waddr (mem_waddr),
        .o_mem_wdata (mem_wdata),
        .i_mem_rdata (mem_rdata)
    );

    sdf_table #(
        .DEPTH (TABLE_DEPTH),
        .AW    (AW)
    ) u_table (
        .i_clk   (i_clk),
        .i_wen   (mem_wen),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_ren   (mem_ren),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (res_load) begin
            r_out_vld <= 1'b1;
        end else if (i_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_load) begin
            r_out <= res;
        end
    end

    assign o_valid     = r_out_vld;
    assign o_out_value = r_out.value;
    assign o_kept      = r_out.kept;
    assign o_overflow  = r_out.overflow;
    assign o_out_last  = r_out.last;

    // ready drops once a transfer is taken (the block stays busy for the scan)
    a_busy_after_accept : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> !o_ready)
        else $error("block ready right after input transfer");

    // a loaded result is presented next cycle
    a_result_presented : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_load |=> o_valid)
        else $error("loaded result not presented");

    // overflow only ever accompanies a kept value
    a_overflow_kept : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (!o_overflow || o_kept))
        else $error("overflow on dropped value");

    // no result is loaded while the sequencer is idle
    a_no_idle_result : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_load |-> !ctrl_idle)
        else $error("result loaded while idle");

endmodule

`default_nettype wire
